### src/scae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scae_pkg
// Shared widths, register indexes and candidate tables for the SPI clock
// attribute encoder.
// ----------------------------------------------------------------------------
package scae_pkg;

    localparam int NS_W     = 32;
    localparam int PCLK_W   = 29;
    localparam int SCK_W    = 28;
    localparam int BPW_W    = 5;
    localparam int CFG_W    = 29;
    localparam int IDX_W    = 3;
    localparam int WANT_W   = NS_W + PCLK_W;
    localparam int CAND_W   = 6;
    localparam int NCAND    = 64;
    localparam int NODES    = NCAND - 1;
    localparam int STAGES   = 8;
    localparam int STG_W    = 3;
    localparam int NUM_W    = PCLK_W + 1;
    localparam int BCAND_W  = 7;
    localparam int RECIP_W  = 34;
    localparam int RECIP_SH = 35;
    localparam int PROD_W   = NUM_W + RECIP_W;

    localparam logic [IDX_W-1:0] REG_PCLK     = 3'd0;
    localparam logic [IDX_W-1:0] REG_SCK      = 3'd1;
    localparam logic [IDX_W-1:0] REG_BPW      = 3'd2;
    localparam logic [IDX_W-1:0] REG_LSB      = 3'd3;
    localparam logic [IDX_W-1:0] REG_PHASE    = 3'd4;
    localparam logic [IDX_W-1:0] REG_POLARITY = 3'd5;

    localparam logic [63:0] NS_PER_SEC = 64'd1000000000;

    typedef logic [WANT_W-1:0] err_t;

    function automatic err_t abs_diff(input err_t a, input err_t b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // delay candidate: prescaler (1,3,5,7) * 2^(s+1) * 1e9
    function automatic err_t dly_have(input logic [CAND_W-1:0] c);
        logic [63:0] v;
        logic [63:0] pre;
        case (c[5:4])
            2'd0:    pre = 64'd1;
            2'd1:    pre = 64'd3;
            2'd2:    pre = 64'd5;
            default: pre = 64'd7;
        endcase
        v = (pre * NS_PER_SEC) << ({1'b0, c[3:0]} + 5'd1);
        return v[WANT_W-1:0];
    endfunction

    // baud divisor = odd factor * 2^shift; odd factor of prescaler*scaler
    function automatic logic [4:0] baud_odd(input logic [CAND_W-1:0] c);
        logic [4:0] pre;
        case (c[5:4])
            2'd0:    pre = 5'd1;
            2'd1:    pre = 5'd3;
            2'd2:    pre = 5'd5;
            default: pre = 5'd7;
        endcase
        return (c[3:0] == 4'd2) ? 5'(pre * 5'd3) : pre;
    endfunction

    // power-of-two part of prescaler*scaler
    function automatic logic [4:0] baud_shift(input logic [CAND_W-1:0] c);
        logic [4:0] s;
        case (c[3:0])
            4'd0:    s = 5'd1;
            4'd1:    s = 5'd2;
            4'd2:    s = 5'd1;
            4'd3:    s = 5'd3;
            default: s = {1'b0, c[3:0]};
        endcase
        return (c[5:4] == 2'd0) ? (s + 5'd1) : s;
    endfunction

    // ceil(2^35 / odd); exact floor for any 30-bit dividend
    function automatic logic [RECIP_W-1:0] baud_recip(input logic [4:0] odd);
        logic [RECIP_W-1:0] m;
        case (odd)
            5'd3:    m = 34'd11453246123;
            5'd5:    m = 34'd6871947674;
            5'd7:    m = 34'd4908534053;
            5'd9:    m = 34'd3817748708;
            5'd15:   m = 34'd2290649225;
            5'd21:   m = 34'd1636178018;
            default: m = '0;            // odd factor one bypasses the multiply
        endcase
        return m;
    endfunction

    // pipeline stage that owns a heap node (root at last stage)
    function automatic logic [STG_W-1:0] node_stage(input int i);
        return STG_W'(STAGES - $clog2(i + 2));
    endfunction

endpackage
`default_nettype wire

### src/scae_delay_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scae_delay_lane
// One delay lane: ns*clk product, 64 candidate errors, registered min tree.
// ----------------------------------------------------------------------------
module scae_delay_lane (
    input  wire logic                          clk,
    input  wire logic [scae_pkg::STAGES-1:0]   stage_load,
    input  wire logic [scae_pkg::NS_W-1:0]     ns,
    input  wire logic [scae_pkg::PCLK_W-1:0]   pclk_hz,
    output logic [scae_pkg::CAND_W-1:0]        best_code
);
    import scae_pkg::*;

    err_t              want_reg;
    err_t              node_err_reg [0:NODES+NCAND-1];
    logic [CAND_W-1:0] node_idx_reg [0:NODES+NCAND-1];

    always_ff @(posedge clk)
    begin
        if (stage_load[0])
        begin
            want_reg <= WANT_W'(ns) * WANT_W'(pclk_hz);
        end
        if (stage_load[1])
        begin
            for (int c = 0; c < NCAND; c++)
            begin
                node_err_reg[NODES+c] <= abs_diff(dly_have(CAND_W'(c)), want_reg);
                node_idx_reg[NODES+c] <= CAND_W'(c);
            end
        end
        // left child holds earlier candidates: it wins ties
        for (int i = 0; i < NODES; i++)
        begin
            if (stage_load[node_stage(i)])
            begin
                if (node_err_reg[2*i+1] <= node_err_reg[2*i+2])
                begin
                    node_err_reg[i] <= node_err_reg[2*i+1];
                    node_idx_reg[i] <= node_idx_reg[2*i+1];
                end
                else
                begin
                    node_err_reg[i] <= node_err_reg[2*i+2];
                    node_idx_reg[i] <= node_idx_reg[2*i+2];
                end
            end
        end
    end

    assign best_code = node_idx_reg[0];

endmodule
`default_nettype wire

### src/scae_baud_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scae_baud_search
// Sequential baud search over 128 candidates, reciprocal-multiply divide.
// ----------------------------------------------------------------------------
module scae_baud_search (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [scae_pkg::PCLK_W-1:0]   pclk_hz,
    input  wire logic [scae_pkg::SCK_W-1:0]    sck_hz,
    output logic                               busy,
    output logic [scae_pkg::BCAND_W-1:0]       best_code
);
    import scae_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_CMP  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [BCAND_W-1:0] cand_reg, cand_next;
    logic [BCAND_W-1:0] best_reg, best_next;
    logic [NUM_W-1:0]   best_err_reg, best_err_next;
    logic               first_reg, first_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [RECIP_W-1:0] recip_reg, recip_next;
    logic               byp_reg, byp_next;
    logic [NUM_W-1:0]   quo_reg, quo_next;

    logic [NUM_W-1:0]   dividend;
    logic [4:0]         odd;
    logic [PROD_W-1:0]  prod;
    logic [NUM_W-1:0]   err;

    assign dividend = cand_reg[BCAND_W-1] ? {pclk_hz, 1'b0} : {1'b0, pclk_hz};
    assign odd      = baud_odd(cand_reg[CAND_W-1:0]);
    assign prod     = PROD_W'(num_reg) * PROD_W'(recip_reg);
    assign err      = (quo_reg > NUM_W'(sck_hz)) ? (quo_reg - NUM_W'(sck_hz))
                                                 : (NUM_W'(sck_hz) - quo_reg);

    always_comb
    begin
        state_next    = state_reg;
        cand_next     = cand_reg;
        best_next     = best_reg;
        best_err_next = best_err_reg;
        first_next    = first_reg;
        num_next      = num_reg;
        recip_next    = recip_reg;
        byp_next      = byp_reg;
        quo_next      = quo_reg;
        case (state_reg)
            ST_LOAD:
            begin
                // strip the power of two, keep the odd factor for the multiply
                num_next   = dividend >> baud_shift(cand_reg[CAND_W-1:0]);
                recip_next = baud_recip(odd);
                byp_next   = (odd == 5'd1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                quo_next   = byp_reg ? num_reg : NUM_W'(prod[PROD_W-1:RECIP_SH]);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (first_reg || (err < best_err_reg))
                begin
                    best_err_next = err;
                    best_next     = cand_reg;
                end
                first_next = 1'b0;
                if (cand_reg == {BCAND_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cand_next  = cand_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (start)
        begin
            cand_next  = '0;
            first_next = 1'b1;
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cand_reg  <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cand_reg  <= cand_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        best_err_reg <= best_err_next;
        num_reg      <= num_next;
        recip_reg    <= recip_next;
        byp_reg      <= byp_next;
        quo_reg      <= quo_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign best_code = best_reg;

endmodule
`default_nettype wire

### src/spi_clock_attribute_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spi_clock_attribute_encoder_top
// Encodes three chip-select delays plus the configured baud target into a
// 32-bit SPI clock and transfer attribute word.
// ----------------------------------------------------------------------------
//  channel | signals                                   | beat
//  --------+-------------------------------------------+-----------------------
//  in      | in_valid, in_stall, three *_ns fields     | valid && !stall
//  out     | out_valid, out_stall, attribute_word      | valid && !stall
//  cfg     | cfg_write, cfg_index, cfg_data            | cfg_write
//
//  One beat per cycle while out_stall is low and no baud search runs; nine
//  register stages (product, error, six min-tree levels, pack register).
//  Each stage advances when it is empty or the one after it advances, so
//  bubbles close up while the output is stalled.
//  The baud search runs after reset and after every write to the clock or
//  target register (128 candidates, each through scale, reciprocal multiply
//  and compare); in_stall stays high meanwhile.
// ----------------------------------------------------------------------------
module spi_clock_attribute_encoder_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [scae_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [scae_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [scae_pkg::NS_W-1:0]     cs_to_clock_ns,
    input  wire logic [scae_pkg::NS_W-1:0]     after_clock_ns,
    input  wire logic [scae_pkg::NS_W-1:0]     after_transfer_ns,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [31:0]                        attribute_word
);
    import scae_pkg::*;

    // configuration registers
    logic [PCLK_W-1:0] pclk_reg;
    logic [SCK_W-1:0]  sck_reg;
    logic [BPW_W-1:0]  bpw_reg;
    logic              lsb_reg;
    logic              phase_reg;
    logic              pol_reg;

    // pipeline control: stage STAGES is the output register
    logic [STAGES:0]   valid_reg;
    logic [STAGES+1:0] ready;
    logic              busy;
    logic              restart;
    logic [BCAND_W-1:0] baud_code;
    logic [CAND_W-1:0] code_a, code_b, code_c;
    logic [31:0]       word_reg;
    logic [3:0]        frame_m1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pclk_reg  <= PCLK_W'(100000000);
            sck_reg   <= SCK_W'(1000000);
            bpw_reg   <= BPW_W'(8);
            lsb_reg   <= 1'b0;
            phase_reg <= 1'b0;
            pol_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PCLK:     pclk_reg  <= cfg_data[PCLK_W-1:0];
                REG_SCK:      sck_reg   <= cfg_data[SCK_W-1:0];
                REG_BPW:      bpw_reg   <= cfg_data[BPW_W-1:0];
                REG_LSB:      lsb_reg   <= cfg_data[0];
                REG_PHASE:    phase_reg <= cfg_data[0];
                REG_POLARITY: pol_reg   <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // baud search restarts on every write to either clock register
    assign restart = cfg_write && ((cfg_index == REG_PCLK) || (cfg_index == REG_SCK));

    scae_baud_search u_baud (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (restart),
        .pclk_hz   (pclk_reg),
        .sck_hz    (sck_reg),
        .busy      (busy),
        .best_code (baud_code)
    );

    always_comb
    begin
        ready[STAGES+1] = !out_stall;
        for (int j = STAGES; j >= 0; j--)
        begin
            ready[j] = !valid_reg[j] || ready[j+1];
        end
    end

    assign in_stall = !ready[0] || busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= in_valid && !busy;
            end
            for (int j = 1; j <= STAGES; j++)
            begin
                if (ready[j])
                begin
                    valid_reg[j] <= valid_reg[j-1];
                end
            end
        end
    end

    // three delay lanes side by side
    scae_delay_lane u_lane_a (
        .clk (clk), .stage_load (ready[STAGES-1:0]), .ns (cs_to_clock_ns),
        .pclk_hz (pclk_reg), .best_code (code_a)
    );
    scae_delay_lane u_lane_b (
        .clk (clk), .stage_load (ready[STAGES-1:0]), .ns (after_clock_ns),
        .pclk_hz (pclk_reg), .best_code (code_b)
    );
    scae_delay_lane u_lane_c (
        .clk (clk), .stage_load (ready[STAGES-1:0]), .ns (after_transfer_ns),
        .pclk_hz (pclk_reg), .best_code (code_c)
    );

    // merge: pack lane results, baud code, frame size and mode bits
    assign frame_m1 = 4'(bpw_reg - 5'd1);

    always_ff @(posedge clk)
    begin
        if (ready[STAGES])
        begin
            word_reg <= {baud_code[6], frame_m1, pol_reg, phase_reg, lsb_reg,
                         code_a[5:4], code_b[5:4], code_c[5:4], baud_code[5:4],
                         code_a[3:0], code_b[3:0], code_c[3:0], baud_code[3:0]};
        end
    end

    assign out_valid      = valid_reg[STAGES];
    assign attribute_word = word_reg;

endmodule
`default_nettype wire

### src/scae_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scae_checker
// Port-level checks for the attribute encoder, bound to the top level.
// ----------------------------------------------------------------------------
module scae_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [scae_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic                          in_stall,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [31:0]                   attribute_word
);
    import scae_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(attribute_word))
        else $error("out payload changed while stalled");

    a_pclk_search: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (cfg_index == REG_PCLK) |=> in_stall)
        else $error("input not held off after clock write");

    a_sck_search: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (cfg_index == REG_SCK) |=> in_stall ##1 in_stall)
        else $error("input not held off after target write");

endmodule

bind spi_clock_attribute_encoder_top scae_checker u_scae_checker (.*);
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SPI clock attribute encoder. A local copy of the
// baud and delay search predicts each attribute word, which is compared in
// order with the words the block returns. A directed table runs first. The
// random part then changes the settings between phases and varies the idle
// and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import scae_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE7 = 3'd7;
    localparam int DRAIN_CYCLES = 12;           // pipeline is 9 deep
    localparam logic [31:0] QUIET_WORD = 32'h7F00_0000;
    localparam longint unsigned DLY_PRE [4]   = '{1, 3, 5, 7};
    localparam longint unsigned BAUD_PRE [4]  = '{2, 3, 5, 7};
    localparam longint unsigned BAUD_SCL [16] = '{2, 4, 6, 8, 16, 32, 64, 128, 256,
        512, 1024, 2048, 4096, 8192, 16384, 32768};

    typedef struct packed {
        logic [31:0] cs_ns;
        logic [31:0] ac_ns;
        logic [31:0] at_ns;
    } timing_req_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [NS_W-1:0] cs_to_clock_ns;
    logic [NS_W-1:0] after_clock_ns;
    logic [NS_W-1:0] after_transfer_ns;
    logic out_valid;
    logic out_stall;
    logic [31:0] attribute_word;

    // shadow copy of the block's registers
    logic [PCLK_W-1:0] pclk_m;
    logic [SCK_W-1:0] sck_m;
    logic [BPW_W-1:0] bpw_m;
    logic lsb_m;
    logic cpha_m;
    logic cpol_m;

    logic [31:0] pending_words[$];
    int fail_count = 0;
    int idle_pct = 0;                   // sender idle chance per cycle
    int stall_pct = 0;                  // receiver stall chance per cycle
    int hold_request = 0;               // long receiver hold-off, in cycles

    spi_clock_attribute_encoder_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cs_to_clock_ns(cs_to_clock_ns),
        .after_clock_ns(after_clock_ns),
        .after_transfer_ns(after_transfer_ns),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .attribute_word(attribute_word)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Best delay code {prescaler, scaler}: smallest |ns*pclk - pre*2^(s+1)*1e9|,
    // first candidate wins on a tie.
    function automatic logic [5:0] best_delay(input logic [31:0] ns);
        logic [63:0] want;
        logic [63:0] have;
        logic [63:0] err;
        logic [63:0] best_err;
        logic [5:0] best;
        want = 64'(ns) * 64'(pclk_m);
        best_err = '1;
        best = '0;
        for (int p = 0; p < 4; p++)
        begin
            for (int s = 0; s < 16; s++)
            begin
                have = DLY_PRE[p] * (64'd2 << s) * 64'd1000000000;
                err = (want > have) ? want - have : have - want;
                if (err < best_err)
                begin
                    best_err = err;
                    best = {2'(p), 4'(s)};
                end
            end
        end
        return best;
    endfunction

    // Best baud code {dbr, prescaler, scaler} against the target SCK.
    function automatic logic [6:0] best_baud();
        logic [63:0] rate;
        logic [63:0] err;
        logic [63:0] best_err;
        logic [6:0] best;
        best_err = '1;
        best = '0;
        for (int d = 0; d < 2; d++)
        begin
            for (int p = 0; p < 4; p++)
            begin
                for (int s = 0; s < 16; s++)
                begin
                    rate = (64'(pclk_m) * 64'(d + 1)) / (BAUD_PRE[p] * BAUD_SCL[s]);
                    err = (rate > 64'(sck_m)) ? rate - 64'(sck_m) : 64'(sck_m) - rate;
                    if (err < best_err)
                    begin
                        best_err = err;
                        best = {1'(d), 2'(p), 4'(s)};
                    end
                end
            end
        end
        return best;
    endfunction

    function automatic logic [31:0] attribute_for(input timing_req_t r);
        logic [5:0] a;
        logic [5:0] b;
        logic [5:0] c;
        logic [6:0] baud;
        logic [4:0] frame_m1;
        a = best_delay(r.cs_ns);
        b = best_delay(r.ac_ns);
        c = best_delay(r.at_ns);
        baud = best_baud();
        frame_m1 = bpw_m - 5'd1;       // out-of-range frame sizes wrap mod 16
        return {baud[6], frame_m1[3:0], cpol_m, cpha_m, lsb_m, a[5:4], b[5:4], c[5:4],
                baud[5:4], a[3:0], b[3:0], c[3:0], baud[3:0]};
    endfunction

    // One register write; cfg_write stays high so back-to-back writes work.
    task automatic cfg_put(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_PCLK:     pclk_m = data[PCLK_W-1:0];
            REG_SCK:      sck_m = data[SCK_W-1:0];
            REG_BPW:      bpw_m = data[BPW_W-1:0];
            REG_LSB:      lsb_m = data[0];
            REG_PHASE:    cpha_m = data[0];
            REG_POLARITY: cpol_m = data[0];
            default:      ;
        endcase
        @(posedge clk);
    endtask

    task automatic cfg_all(input logic [CFG_W-1:0] pclk, input logic [CFG_W-1:0] sck,
                           input logic [CFG_W-1:0] bpw, input logic [2:0] mode);
        cfg_put(REG_PCLK, pclk);
        cfg_put(REG_SCK, sck);
        cfg_put(REG_BPW, bpw);
        cfg_put(REG_LSB, {28'($urandom), mode[0]});
        cfg_put(REG_PHASE, {28'($urandom), mode[1]});
        cfg_put(REG_POLARITY, {28'($urandom), mode[2]});
        cfg_put($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, CFG_W'($urandom));
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one beat; in_valid is only dropped when an idle gap is taken.
    task automatic send_req(input timing_req_t r, input bit use_lit, input logic [31:0] lit);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cs_to_clock_ns <= r.cs_ns;
        after_clock_ns <= r.ac_ns;
        after_transfer_ns <= r.at_ns;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_words.push_back(use_lit ? lit : attribute_for(r));
    endtask

    // Close a phase: stop offering, drain, let the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_ns();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 2000);
            2: return $urandom_range(0, 5000000);
            default: return 32'(20 * DLY_PRE[$urandom_range(0, 3)]) << $urandom_range(0, 15);
        endcase
    endfunction

    // Receiver: checks beats, then picks the next stall value.
    initial
    begin
        int hold_left;
        logic [31:0] want_word;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_words.size() == 0)
                begin
                    $error("attribute_word: unexpected beat %h", attribute_word);
                    fail_count++;
                end
                else
                begin
                    want_word = pending_words.pop_front();
                    if (attribute_word !== want_word)
                    begin
                        $error("attribute_word: expected %h, got %h", want_word,
                               attribute_word);
                        fail_count++;
                    end
                end
            end
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        timing_req_t dir_rows [14];
        timing_req_t r;
        int idle_modes [4];
        int stall_modes [4];
        int n_items;

        dir_rows = '{
            '{32'd0, 32'd0, 32'd0},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
            '{32'hFFFF_FFFF, 32'd0, 32'd0},
            '{32'd0, 32'hFFFF_FFFF, 32'd0},
            '{32'd0, 32'd0, 32'hFFFF_FFFF},
            '{32'd1, 32'd2, 32'd10},
            '{32'd20, 32'd60, 32'd100},         // exact hits at 100 MHz
            '{32'd30, 32'd40, 32'd140},         // 30 a midpoint; 40 and 140 exact hits
            '{32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA},
            '{32'd1310720, 32'd9175040, 32'd6553600},
            '{32'd655360, 32'd3932160, 32'd45875200},
            '{32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_FFFF},
            '{32'd123456, 32'd999999, 32'd31},
            '{32'hDEAD_BEEF, 32'h1234_5678, 32'h0F0F_0F0F}};
        idle_modes = '{0, 52, 0, 33};
        stall_modes = '{0, 0, 52, 33};

        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        cs_to_clock_ns <= '0;
        after_clock_ns <= '0;
        after_transfer_ns <= '0;
        pclk_m = 29'd100000000;
        sck_m = 28'd1000000;
        bpw_m = 5'd8;
        lsb_m = 1'b0;
        cpha_m = 1'b0;
        cpol_m = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings: predicted words.
        foreach (dir_rows[i])
            send_req(dir_rows[i], 1'b0, '0);
        drain();

        // Directed, zero clock: every search settles on candidate zero, so the
        // word holds only frame size 16 and the three mode bits.
        cfg_all(29'd0, 29'd1, 29'd16, 3'b111);
        foreach (dir_rows[i])
            send_req(dir_rows[i], 1'b1, QUIET_WORD);
        drain();

        // Random phases; the first four pin the register extremes.
        for (int ph = 0; ph < 12; ph++)
        begin
            idle_pct = idle_modes[ph % 4];
            stall_pct = stall_modes[ph % 4];
            case (ph)
                0: cfg_all(29'h1FFF_FFFF, 29'h0FFF_FFFF, 29'd31, 3'b000);
                1: cfg_all(29'd1, 29'd0, 29'd0, 3'b101);
                2: cfg_all(29'd300000000, 29'd150000000, 29'd4, 3'b010);
                3: cfg_all(29'd1, 29'd1, 29'd17, 3'b111);
                default: cfg_all(CFG_W'($urandom_range(1, 300000000)),
                                 CFG_W'($urandom_range(1, 20000000)),
                                 CFG_W'($urandom_range(4, 16)), 3'($urandom));
            endcase
            // Long output hold-off while the sender keeps pushing.
            if (ph == 4)
                hold_request = 300;
            n_items = 100;
            for (int k = 0; k < n_items; k++)
            begin
                r.cs_ns = rand_ns();
                r.ac_ns = rand_ns();
                r.at_ns = rand_ns();
                send_req(r, 1'b0, '0);
            end
            drain();
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
src/scae_pkg.sv
src/scae_delay_lane.sv
src/scae_baud_search.sv
src/spi_clock_attribute_encoder_top.sv
src/scae_checker.sv
tb/tb_top.sv
